### rtl/pid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed loop package
// Beat types, register indexes and fixed constants for the speed loop.
// ----------------------------------------------------------------------------
package pid_pkg;

   typedef struct packed {
      logic signed [15:0] target_speed;
      logic signed [15:0] measured_speed;
      logic [19:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [23:0] control_out;
      logic [15:0]        pwm_duty;
   } rsp_type;

   localparam logic [2:0] REG_PROP  = 3'd0;
   localparam logic [2:0] REG_INTEG = 3'd1;
   localparam logic [2:0] REG_DERIV = 3'd2;
   localparam logic [2:0] REG_TAU   = 3'd3;
   localparam logic [2:0] REG_LIMIT = 3'd4;
   localparam logic [2:0] REG_DUTY  = 3'd5;

   // 2 * 10^6 * 2^16
   localparam logic [40:0] INTEG_DIV = 41'd131072000000;

endpackage

### rtl/pid_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID shared arithmetic unit
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module pid_muldiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_div,
   input  logic [63:0] op_a,      // multiplicand or dividend
   input  logic [63:0] op_b,      // multiplier or divisor
   input  logic [6:0]  bits,      // multiplier width or quotient width
   output logic        done,
   output logic [63:0] result,    // product or quotient
   output logic [63:0] remainder
);

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;       // mul: shifted multiplicand, div: dividend
   logic [63:0] b_ff, b_in;       // mul: multiplier, div: divisor
   logic [63:0] acc_ff, acc_in;   // mul: product, div: partial remainder
   logic [63:0] q_ff, q_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         div_in  = is_div;
         cnt_in  = bits;
         b_in    = op_b;
         acc_in  = '0;
         q_in    = '0;
         // divider walks the dividend from its top quotient bit down
         a_in    = is_div ? (op_a << (7'd64 - bits)) : op_a;
      end else if (busy_ff) begin
         if (div_ff) begin
            trial = {acc_ff, a_ff[63]} - {1'b0, b_ff};
            if (!trial[64]) begin
               acc_in = trial[63:0];
               q_in   = {q_ff[62:0], 1'b1};
            end else begin
               acc_in = {acc_ff[62:0], a_ff[63]};
               q_in   = {q_ff[62:0], 1'b0};
            end
            a_in = {a_ff[62:0], 1'b0};
         end else begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = {a_ff[62:0], 1'b0};
            b_in = {1'b0, b_ff[63:1]};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
   end

   assign done      = done_ff;
   assign result    = div_ff ? q_ff : acc_ff;
   assign remainder = acc_ff;

endmodule

### rtl/pid_speed_loop_with_duty_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed loop with duty update
// Fixed-point PID on Q8.8 speeds, updates a kept 16-bit PWM duty level.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each item runs through a sequencer that drives
// a single shared bit-serial unit (one product or quotient bit per cycle):
// P multiply, integral multiply/divide/multiply/multiply/round-divide,
// derivative multiplies and divide, duty multiply. Each serial step has a
// launch and a done, and a step between the divide and the duty multiply
// sums and saturates the terms without the serial unit. The request side
// stays stalled while an item is in flight and while a finished result is
// stalled, so the next request can be taken only after the result is
// loaded. No clearing pass after reset.
module pid_speed_loop_with_duty_update (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pid_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pid_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [30:0]      csr_data
);

   // sequencer steps
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_P     = 4'd1;  // prop_gain * |e|
   localparam logic [3:0] ST_IM    = 4'd2;  // integ_gain * |sum|
   localparam logic [3:0] ST_ID    = 4'd3;  // m / dd
   localparam logic [3:0] ST_IQ    = 4'd4;  // q1 * dt
   localparam logic [3:0] ST_IR    = 4'd5;  // r1 * dt
   localparam logic [3:0] ST_IRD   = 4'd6;  // (r1*dt + dd/2) / dd
   localparam logic [3:0] ST_DA    = 4'd7;  // deriv_gain * |dm|
   localparam logic [3:0] ST_DB    = 4'd8;  // |2tau - T| * |deriv_acc|
   localparam logic [3:0] ST_DD    = 4'd9;  // |num| / den
   localparam logic [3:0] ST_DUTY  = 4'd10; // |out| * duty_gain
   localparam logic [3:0] ST_DA2   = 4'd11; // x 15625
   localparam logic [3:0] ST_SUM   = 4'd15; // sum terms, no serial step

   logic [30:0] prop_ff, integ_ff, deriv_ff;
   logic [19:0] tau_ff;
   logic [14:0] lim_ff;
   logic [15:0] dgain_ff;

   logic signed [16:0] integ_acc_ff, last_err_ff;
   logic signed [15:0] last_meas_ff;
   logic signed [23:0] deriv_acc_ff;
   logic [15:0]        duty_ff;

   logic [3:0]         st_ff;
   logic               started_ff;
   logic signed [16:0] err_ff;
   logic signed [15:0] meas_ff;
   logic [19:0]        dt_ff;
   logic signed [17:0] sum_ff;
   logic signed [16:0] dm_ff;
   logic signed [33:0] p_ff;
   logic [63:0]        t0_ff, t1_ff;   // scratch
   logic signed [63:0] num_ff;
   logic signed [17:0] i_ff;
   logic signed [23:0] d_ff, out_ff;

   logic               rsp_valid_ff;
   pid_pkg::rsp_type   rsp_ff;

   logic        mu_start, mu_div, mu_done;
   logic [63:0] mu_a, mu_b, mu_res, mu_rem;
   logic [6:0]  mu_bits;

   pid_muldiv u_md (
      .clock(clock), .reset(reset), .start(mu_start), .is_div(mu_div),
      .op_a(mu_a), .op_b(mu_b), .bits(mu_bits), .done(mu_done),
      .result(mu_res), .remainder(mu_rem)
   );

   wire req_take = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

   // magnitudes used across steps
   logic [63:0] sign_num_mag, two_tau_t_mag, dacc_mag, out_mag;
   logic signed [21:0] two_tau_t;
   logic [21:0] den_base;
   always_comb begin
      two_tau_t     = $signed({1'b0, tau_ff, 1'b0}) - $signed({2'b0, dt_ff});
      two_tau_t_mag = two_tau_t[21] ? 64'(-two_tau_t) : 64'(two_tau_t);
      dacc_mag      = deriv_acc_ff[23] ? 64'(-deriv_acc_ff) : 64'(deriv_acc_ff);
      sign_num_mag  = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
      out_mag       = out_ff[23] ? 64'(-out_ff) : 64'(out_ff);
      den_base      = 22'({tau_ff, 1'b0}) + 22'(dt_ff);
   end

   // operand selection for the step being launched
   always_comb begin
      mu_start = !started_ff && (st_ff != ST_IDLE) && (st_ff != ST_SUM);
      mu_div   = 1'b0;
      mu_a     = '0;
      mu_b     = '0;
      mu_bits  = 7'd32;
      case (st_ff)
         ST_P: begin
            mu_a = 64'(prop_ff);
            mu_b = err_ff[16] ? 64'(-err_ff) : 64'(err_ff);
            mu_bits = 7'd17;
         end
         ST_IM: begin
            mu_a = 64'(integ_ff);
            mu_b = sum_ff[17] ? 64'(-sum_ff) : 64'(sum_ff);
            mu_bits = 7'd18;
         end
         ST_ID: begin
            mu_div = 1'b1; mu_a = t0_ff; mu_b = 64'(pid_pkg::INTEG_DIV);
            mu_bits = 7'd49;
         end
         ST_IQ: begin
            mu_a = t0_ff; mu_b = 64'(dt_ff); mu_bits = 7'd20;
         end
         ST_IR: begin
            mu_a = t1_ff; mu_b = 64'(dt_ff); mu_bits = 7'd20;
         end
         ST_IRD: begin
            mu_div = 1'b1; mu_a = t1_ff + 64'(pid_pkg::INTEG_DIV >> 1);
            mu_b = 64'(pid_pkg::INTEG_DIV); mu_bits = 7'd61;
         end
         ST_DA: begin
            mu_a = 64'(deriv_ff);
            mu_b = dm_ff[16] ? 64'(-dm_ff) : 64'(dm_ff);
            mu_bits = 7'd17;
         end
         ST_DA2: begin
            mu_a = t0_ff; mu_b = 64'd15625; mu_bits = 7'd14;
         end
         ST_DB: begin
            mu_a = two_tau_t_mag; mu_b = dacc_mag; mu_bits = 7'd24;
         end
         ST_DD: begin
            mu_div = 1'b1;
            mu_a = sign_num_mag + 64'({den_base, 8'd0});
            mu_b = 64'({den_base, 9'd0}); mu_bits = 7'd64;
         end
         ST_DUTY: begin
            mu_a = out_mag; mu_b = 64'(dgain_ff); mu_bits = 7'd16;
         end
         default: ;
      endcase
   end

   // combinational finishing pieces
   logic [63:0] p_mag;
   logic signed [63:0] itot, dneg, osum, duty_sum, dscaled;
   logic signed [63:0] dterm_a, dterm_b;
   always_comb begin
      p_mag    = (mu_res + 64'd32768) >> 16;
      itot     = 64'(integ_acc_ff) + (sum_ff[17] ? -$signed(t0_ff + mu_res)
                                                   : $signed(t0_ff + mu_res));
      dterm_a  = dm_ff[16] ? -$signed(mu_res) : $signed(mu_res);
      dterm_b  = (two_tau_t[21] ^ deriv_acc_ff[23]) ? -$signed({mu_res[54:0], 9'd0})
                                                    : $signed({mu_res[54:0], 9'd0});
      dneg     = num_ff[63] ? $signed(mu_res) : -$signed(mu_res);
      osum     = 64'(p_ff) + 64'(i_ff) + 64'(d_ff);
      dscaled  = out_ff[23] ? -$signed((mu_res + 64'd128) >> 8)
                            : $signed((mu_res + 64'd128) >> 8);
      duty_sum = 64'($signed({1'b0, duty_ff})) + dscaled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff <= 31'd32768; integ_ff <= 31'd3277; deriv_ff <= 31'd655;
         tau_ff <= 20'd20000; lim_ff <= 15'd256; dgain_ff <= 16'd182;
         integ_acc_ff <= '0; last_err_ff <= '0; last_meas_ff <= '0;
         deriv_acc_ff <= '0; duty_ff <= 16'd32768;
         st_ff <= ST_IDLE; started_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               pid_pkg::REG_PROP:  prop_ff  <= csr_data;
               pid_pkg::REG_INTEG: integ_ff <= csr_data;
               pid_pkg::REG_DERIV: deriv_ff <= csr_data;
               pid_pkg::REG_TAU:   tau_ff   <= csr_data[19:0];
               pid_pkg::REG_LIMIT: lim_ff   <= csr_data[14:0];
               pid_pkg::REG_DUTY:  dgain_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (mu_start) started_ff <= 1'b1;
         if (mu_done) started_ff <= 1'b0;
         if (req_take) begin
            err_ff  <= 17'(req_data.target_speed) - 17'(req_data.measured_speed);
            sum_ff  <= 18'(last_err_ff) + 18'(req_data.target_speed)
                       - 18'(req_data.measured_speed);
            dm_ff   <= 17'(req_data.measured_speed) - 17'(last_meas_ff);
            meas_ff <= req_data.measured_speed;
            dt_ff   <= (req_data.elapsed_us == '0) ? 20'd1 : req_data.elapsed_us;
            st_ff   <= ST_P;
         end else if (mu_done) begin
            case (st_ff)
               ST_P: begin
                  p_ff  <= err_ff[16] ? -$signed(34'(p_mag)) : $signed(34'(p_mag));
                  st_ff <= ST_IM;
               end
               ST_IM:  begin t0_ff <= mu_res; st_ff <= ST_ID; end
               ST_ID:  begin t0_ff <= mu_res; t1_ff <= mu_rem; st_ff <= ST_IQ; end
               ST_IQ:  begin t0_ff <= mu_res; st_ff <= ST_IR; end
               ST_IR:  begin t1_ff <= mu_res; st_ff <= ST_IRD; end
               ST_IRD: begin
                  if (itot > $signed(64'(lim_ff))) i_ff <= 18'(lim_ff);
                  else if (itot < -$signed(64'(lim_ff))) i_ff <= -18'(lim_ff);
                  else i_ff <= 18'(itot);
                  st_ff <= ST_DA;
               end
               ST_DA:  begin t0_ff <= mu_res; st_ff <= ST_DA2; end
               ST_DA2: begin num_ff <= dterm_a; st_ff <= ST_DB; end
               ST_DB:  begin num_ff <= num_ff + dterm_b; st_ff <= ST_DD; end
               ST_DD: begin
                  if (dneg > 64'sd8388607) d_ff <= 24'h7FFFFF;
                  else if (dneg < -64'sd8388608) d_ff <= 24'h800000;
                  else d_ff <= 24'(dneg);
                  st_ff <= ST_SUM; // finish step below
               end
               ST_DUTY: begin
                  if (duty_sum > 64'sd65535) duty_ff <= 16'hFFFF;
                  else if (duty_sum < 64'sd0) duty_ff <= 16'h0000;
                  else duty_ff <= 16'(duty_sum);
                  rsp_ff.control_out <= out_ff;
                  rsp_ff.pwm_duty <= (duty_sum > 64'sd65535) ? 16'hFFFF :
                                     (duty_sum < 64'sd0) ? 16'h0000 : 16'(duty_sum);
                  rsp_valid_ff <= 1'b1;
                  integ_acc_ff <= 17'(i_ff);
                  deriv_acc_ff <= d_ff;
                  last_err_ff  <= err_ff;
                  last_meas_ff <= meas_ff;
                  st_ff <= ST_IDLE;
               end
               default: ;
            endcase
         end else if (st_ff == ST_SUM) begin
            // sum the terms and saturate, then launch the duty multiply
            if (osum > 64'sd8388607) out_ff <= 24'h7FFFFF;
            else if (osum < -64'sd8388608) out_ff <= 24'h800000;
            else out_ff <= 24'(osum);
            st_ff <= ST_DUTY;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req_take) else $error("take while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("rsp dropped");
   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      (i_ff <= 18'sd32767 && i_ff >= -18'sd32767) || st_ff <= ST_IRD)
      else $error("integral out of range");
`endif

endmodule
